/* src/mqra_pkg.sv */
// Shared widths, payload types and sequencer codes for the mass quadrupole rate accumulator.
package mqra_pkg;

  localparam int FRAC_BITS = 16;
  localparam int NSUM      = 6;
  localparam int SUM_W     = 64;
  localparam int HALF      = 32;
  localparam int MUL_W     = HALF + 1;
  localparam int PRD_W     = 2 * MUL_W;
  localparam int CNT_W     = 4;

  // p = floor(v*x / 2^F), s = sum of three p, t = one tensor term
  localparam int PW  = 64 - FRAC_BITS;
  localparam int SW  = PW + 2;
  localparam int TW  = PW + 3;
  // m = floor(vol*dens / 2^F)
  localparam int MW  = 62 - FRAC_BITS;
  // full m*t product, contribution after the shift, widened sum
  localparam int AW  = MW + TW;
  localparam int CW  = AW - FRAC_BITS;
  localparam int NW  = ((CW > SUM_W) ? CW : SUM_W) + 1;
  // divide-by-three dividend, processed one byte per step
  localparam int DW  = SW + 2;
  localparam int DB  = (DW + 7) / 8;
  localparam int DWP = DB * 8;

  localparam logic [DWP-1:0] DIV_BIAS = DWP'(3) << SW;
  localparam logic [DWP-1:0] TT_BIAS  = DWP'(1) << SW;
  // floor(v/3) == (v*683) >> 11 for v below 768
  localparam logic [9:0]     RECIP3   = 10'd683;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // component order of the sums
  localparam logic [2:0] C_XX = 3'd0;
  localparam logic [2:0] C_XY = 3'd1;
  localparam logic [2:0] C_XZ = 3'd2;
  localparam logic [2:0] C_YY = 3'd3;
  localparam logic [2:0] C_YZ = 3'd4;
  localparam logic [2:0] C_ZZ = 3'd5;

  // velocity-position products, p index
  localparam logic [CNT_W-1:0] P_XX = 4'd0;
  localparam logic [CNT_W-1:0] P_YY = 4'd1;
  localparam logic [CNT_W-1:0] P_ZZ = 4'd2;
  localparam logic [CNT_W-1:0] P_XY = 4'd3;
  localparam logic [CNT_W-1:0] P_YX = 4'd4;
  localparam logic [CNT_W-1:0] P_XZ = 4'd5;
  localparam logic [CNT_W-1:0] P_ZX = 4'd6;
  localparam logic [CNT_W-1:0] P_YZ = 4'd7;
  localparam logic [CNT_W-1:0] P_ZY = 4'd8;
  localparam int               NPROD = 9;

  // product sequence steps
  localparam logic [CNT_W-1:0] STEP_MASS = 4'd0;
  localparam logic [CNT_W-1:0] STEP_P0   = 4'd1;
  localparam logic [CNT_W-1:0] PROD_LAST = STEP_P0 + 4'(NPROD);

  // partial products of m*t: low/high half of m times low/high half of t
  localparam logic [1:0] PP_LL = 2'd0;
  localparam logic [1:0] PP_LH = 2'd1;
  localparam logic [1:0] PP_HL = 2'd2;
  localparam logic [1:0] PP_HH = 2'd3;
  localparam logic [CNT_W-1:0] MAC_LAST = 4'd4;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PROD = 6'b000010,
    S_DIV  = 6'b000100,
    S_TERM = 6'b001000,
    S_MAC  = 6'b010000,
    S_ADD  = 6'b100000
  } state_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [30:0] cell_volume;
    logic        [30:0] density;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic               last_cell;
  } cell_item_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] rate_xx;
    logic signed [SUM_W-1:0] rate_xy;
    logic signed [SUM_W-1:0] rate_xz;
    logic signed [SUM_W-1:0] rate_yy;
    logic signed [SUM_W-1:0] rate_yz;
    logic signed [SUM_W-1:0] rate_zz;
    logic                    saturated;
  } rate_item_t;

endpackage

/* src/mqra_if.sv */
// Valid/ready channel interfaces for cell items and rate results.
interface mqra_cell_if;
  import mqra_pkg::*;

  logic       valid;
  logic       ready;
  cell_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mqra_rate_if;
  import mqra_pkg::*;

  logic       valid;
  logic       ready;
  rate_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* src/mass_quadrupole_rate_accumulator_unit.sv */
// Top level: mass quadrupole rate accumulator around one shared 33x33 multiplier.
// Each cell runs 11 product steps (mass, nine products, one store), DB = 7 divide-by-three steps,
// a term, multiply-accumulate and add sequence per component, and idle, which takes the next cell.
// A last cell's result waits in an output register; its final add holds while an older result waits.
// Cells are taken only in idle, one at a time, as set by the shared multiplier and its sequencer.
// Synchronous reset clears the sums, the saturation flag, the sequencer and the output valid.
module mass_quadrupole_rate_accumulator_unit (
  input logic        clk,
  input logic        rst,
  mqra_cell_if.sink  cells,
  mqra_rate_if.source rates
);
  import mqra_pkg::*;

  state_t                  state;
  logic [CNT_W-1:0]        cnt;
  logic [2:0]              comp;
  logic signed [SUM_W-1:0] sums [0:NSUM-1];
  logic                    sat_seen;
  logic                    out_valid;

  cell_item_t              in_q;
  logic signed [PRD_W-1:0] prod_q;
  logic [MW-1:0]           m_reg;
  logic signed [PW-1:0]    p [0:NPROD-1];
  logic [DWP-1:0]          div_reg;
  logic [1:0]              rem;
  logic signed [TW-1:0]    t_reg;
  logic signed [AW-1:0]    acc;
  rate_item_t              rate_q;

  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;
  logic signed [PRD_W-1:0] mul_p;
  logic [DWP-1:0]          div_init;
  logic [9:0]              div_v;
  logic [19:0]             div_qv;
  logic [7:0]              q_digit;
  logic [9:0]              r_full;
  logic signed [TW-1:0]    tt;
  logic signed [TW-1:0]    t_sel;
  logic [1:0]              pp_idx;
  logic signed [AW-1:0]    pp_ext;
  logic signed [AW-1:0]    pp_sh;
  logic signed [CW-1:0]    contrib;
  logic signed [NW-1:0]    sum_wide;
  logic [NW-SUM_W:0]       sum_top;
  logic                    sat_hit;
  logic signed [SUM_W-1:0] sum_fin;
  logic                    emit;
  logic                    add_hold;
  logic                    out_load;

  assign cells.ready = (state == S_IDLE);
  assign rates.valid = out_valid;
  assign rates.data  = rate_q;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_PROD: begin
        case (cnt)
          STEP_MASS: begin
            mul_a = MUL_W'(in_q.cell_volume);
            mul_b = MUL_W'(in_q.density);
          end
          STEP_P0 + P_XX: begin
            mul_a = MUL_W'(in_q.vel_x);
            mul_b = MUL_W'(in_q.pos_x);
          end
          STEP_P0 + P_YY: begin
            mul_a = MUL_W'(in_q.vel_y);
            mul_b = MUL_W'(in_q.pos_y);
          end
          STEP_P0 + P_ZZ: begin
            mul_a = MUL_W'(in_q.vel_z);
            mul_b = MUL_W'(in_q.pos_z);
          end
          STEP_P0 + P_XY: begin
            mul_a = MUL_W'(in_q.vel_x);
            mul_b = MUL_W'(in_q.pos_y);
          end
          STEP_P0 + P_YX: begin
            mul_a = MUL_W'(in_q.vel_y);
            mul_b = MUL_W'(in_q.pos_x);
          end
          STEP_P0 + P_XZ: begin
            mul_a = MUL_W'(in_q.vel_x);
            mul_b = MUL_W'(in_q.pos_z);
          end
          STEP_P0 + P_ZX: begin
            mul_a = MUL_W'(in_q.vel_z);
            mul_b = MUL_W'(in_q.pos_x);
          end
          STEP_P0 + P_YZ: begin
            mul_a = MUL_W'(in_q.vel_y);
            mul_b = MUL_W'(in_q.pos_z);
          end
          STEP_P0 + P_ZY: begin
            mul_a = MUL_W'(in_q.vel_z);
            mul_b = MUL_W'(in_q.pos_y);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      S_MAC: begin
        case (cnt[1:0])
          PP_LL: begin
            mul_a = MUL_W'(m_reg[HALF-1:0]);
            mul_b = MUL_W'(t_reg[HALF-1:0]);
          end
          PP_LH: begin
            mul_a = MUL_W'(m_reg[HALF-1:0]);
            mul_b = MUL_W'($signed(t_reg[TW-1:HALF]));
          end
          PP_HL: begin
            mul_a = MUL_W'(m_reg[MW-1:HALF]);
            mul_b = MUL_W'(t_reg[HALF-1:0]);
          end
          PP_HH: begin
            mul_a = MUL_W'(m_reg[MW-1:HALF]);
            mul_b = MUL_W'($signed(t_reg[TW-1:HALF]));
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // dividend 2*s, biased positive so that byte-wise division by three floors correctly
  assign div_init = ((DWP'(p[P_XX]) + DWP'(p[P_YY]) + DWP'(p[P_ZZ])) <<< 1) + DIV_BIAS;
  assign div_v    = {rem, div_reg[DWP-1 -: 8]};
  assign div_qv   = 20'(div_v) * 20'(RECIP3);
  assign q_digit  = div_qv[18:11];
  assign r_full   = div_v - 10'(q_digit) * 10'd3;
  assign tt       = TW'(div_reg - TT_BIAS);

  always_comb begin
    case (comp)
      C_XX:    t_sel = (TW'(p[P_XX]) <<< 1) - tt;
      C_XY:    t_sel = TW'(p[P_XY]) + TW'(p[P_YX]);
      C_XZ:    t_sel = TW'(p[P_XZ]) + TW'(p[P_ZX]);
      C_YY:    t_sel = (TW'(p[P_YY]) <<< 1) - tt;
      C_YZ:    t_sel = TW'(p[P_YZ]) + TW'(p[P_ZY]);
      C_ZZ:    t_sel = (TW'(p[P_ZZ]) <<< 1) - tt;
      default: t_sel = '0;
    endcase
  end

  // partial product held in prod_q, indexed by cnt - 1
  assign pp_idx = 2'(cnt - 4'd1);
  assign pp_ext = AW'(prod_q);

  always_comb begin
    case (pp_idx)
      PP_LL:   pp_sh = pp_ext;
      PP_LH:   pp_sh = pp_ext <<< HALF;
      PP_HL:   pp_sh = pp_ext <<< HALF;
      PP_HH:   pp_sh = pp_ext <<< (2 * HALF);
      default: pp_sh = '0;
    endcase
  end

  // saturating add of floor(m*t / 2^F)
  assign contrib  = CW'(acc >>> FRAC_BITS);
  assign sum_wide = NW'(sums[comp]) + NW'(contrib);
  assign sum_top  = sum_wide[NW-1:SUM_W-1];
  assign sat_hit  = !((&sum_top) || !(|sum_top));
  assign sum_fin  = sat_hit ? (sum_wide[NW-1] ? SUM_MIN : SUM_MAX) : sum_wide[SUM_W-1:0];

  assign emit     = (state == S_ADD) && (comp == C_ZZ) && in_q.last_cell;
  assign add_hold = emit && out_valid && !rates.ready;
  assign out_load = emit && !add_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      comp      <= C_XX;
      sat_seen  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NSUM; i++) begin
        sums[i] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rates.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cells.valid) begin
            state <= S_PROD;
            cnt   <= '0;
          end
        end
        S_PROD: begin
          if (cnt == PROD_LAST) begin
            state <= S_DIV;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DIV: begin
          if (cnt == CNT_W'(DB - 1)) begin
            state <= S_TERM;
            cnt   <= '0;
            comp  <= C_XX;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_TERM: begin
          state <= S_MAC;
          cnt   <= '0;
        end
        S_MAC: begin
          if (cnt == MAC_LAST) begin
            state <= S_ADD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ADD: begin
          // hold while the previous result still waits
          if (!add_hold) begin
            if (out_load) begin
              for (int i = 0; i < NSUM; i++) begin
                sums[i] <= '0;
              end
              sat_seen <= 1'b0;
            end else begin
              sums[comp] <= sum_fin;
              if (sat_hit) begin
                sat_seen <= 1'b1;
              end
            end
            if (comp == C_ZZ) begin
              state <= S_IDLE;
            end else begin
              comp  <= comp + 1'b1;
              state <= S_TERM;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cells.valid && cells.ready) begin
      in_q <= cells.data;
    end
    if (state == S_PROD || (state == S_MAC && cnt != MAC_LAST)) begin
      prod_q <= mul_p;
    end
    if (state == S_PROD) begin
      if (cnt == STEP_P0) begin
        m_reg <= prod_q[MW+FRAC_BITS-1:FRAC_BITS];
      end else if (cnt > STEP_P0) begin
        p[4'(cnt - STEP_P0 - 4'd1)] <= prod_q[PW+FRAC_BITS-1:FRAC_BITS];
      end
      if (cnt == PROD_LAST) begin
        div_reg <= div_init;
        rem     <= '0;
      end
    end
    if (state == S_DIV) begin
      div_reg <= {div_reg[DWP-9:0], q_digit};
      rem     <= r_full[1:0];
    end
    if (state == S_TERM) begin
      t_reg <= t_sel;
      acc   <= '0;
    end
    if (state == S_MAC && cnt != '0) begin
      acc <= acc + pp_sh;
    end
    if (out_load) begin
      rate_q.rate_xx   <= sums[C_XX];
      rate_q.rate_xy   <= sums[C_XY];
      rate_q.rate_xz   <= sums[C_XZ];
      rate_q.rate_yy   <= sums[C_YY];
      rate_q.rate_yz   <= sums[C_YZ];
      rate_q.rate_zz   <= sum_fin;
      rate_q.saturated <= sat_seen | sat_hit;
    end
  end

  a_start: assert property (@(posedge clk) disable iff (rst)
    cells.valid && cells.ready |=> state == S_PROD && cnt == '0 && !cells.ready)
    else $error("cell transfer did not start the product sequence");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    out_load |=> rates.valid && !sat_seen && sums[C_XX] == '0 && sums[C_ZZ] == '0)
    else $error("sums not cleared after emitting a result");

  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rates.valid) |-> $past(state == S_ADD && comp == C_ZZ && in_q.last_cell))
    else $error("result raised outside the final add of a last cell");

  a_sticky: assert property (@(posedge clk) disable iff (rst)
    state == S_ADD && sat_hit && !add_hold && !out_load |=> sat_seen)
    else $error("saturation not recorded");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> cnt < CNT_W'(DB))
    else $error("division step counter overran");

endmodule
